// ===== design/mvx_pkg.sv =====
// Shared types and constants for the 4x4 matrix-vector transform engine.
package mvx_pkg;

  // Arithmetic widths (signed fixed point, WORD_BITS wide, FRAC_BITS fraction)
  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int IO_BITS    = 32;
  localparam int MAT_DIM    = 4;
  localparam int IDX_BITS   = $clog2(MAT_DIM);
  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int PAIR_BITS  = PROD_BITS + 1;
  localparam int SUM_BITS   = PROD_BITS + 2;
  localparam int SHIFT_BITS = SUM_BITS - FRAC_BITS;

  // Front-to-back queue; depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_e;

  typedef struct packed {
    op_e                        kind;
    logic [1:0]                 row;
    logic [1:0]                 col;
    logic signed [IO_BITS-1:0]  entry_value;
    logic signed [IO_BITS-1:0]  vec_x;
    logic signed [IO_BITS-1:0]  vec_y;
    logic signed [IO_BITS-1:0]  vec_z;
    logic signed [IO_BITS-1:0]  vec_w;
  } in_item_t;

  typedef struct packed {
    logic signed [IO_BITS-1:0]  out_x;
    logic signed [IO_BITS-1:0]  out_y;
    logic signed [IO_BITS-1:0]  out_z;
    logic signed [IO_BITS-1:0]  out_w;
    logic                       saturated;
  } out_item_t;

  // Classified work entry: a load carries its value in vec[0]
  typedef struct packed {
    op_e                        op;
    logic [IDX_BITS-1:0]        row;
    logic [IDX_BITS-1:0]        col;
    logic [MAT_DIM-1:0][WORD_BITS-1:0] vec;
  } work_t;

  // Handshake between front queue and back pipeline
  typedef struct packed {
    logic valid;
  } qstat_t;

  typedef struct packed {
    logic pop;
  } qctrl_t;

endpackage

// ===== design/mvx_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
module mvx_front import mvx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output qstat_t   q_stat_o,
  output work_t    q_item_o,
  input  qctrl_t   q_ctrl_i
);

  work_t                entry_d;
  work_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;
  logic                 push;
  logic                 pop;
  logic                 full;

  // Classify: keep the low word bits of each value field
  always_comb begin
    entry_d     = '0;
    entry_d.op  = in_item_i.kind;
    unique case (in_item_i.kind)
      OP_LOAD: begin
        entry_d.row    = in_item_i.row;
        entry_d.col    = in_item_i.col;
        entry_d.vec[0] = in_item_i.entry_value[WORD_BITS-1:0];
      end
      OP_XFORM: begin
        entry_d.vec[0] = in_item_i.vec_x[WORD_BITS-1:0];
        entry_d.vec[1] = in_item_i.vec_y[WORD_BITS-1:0];
        entry_d.vec[2] = in_item_i.vec_z[WORD_BITS-1:0];
        entry_d.vec[3] = in_item_i.vec_w[WORD_BITS-1:0];
      end
      default: entry_d.op = OP_LOAD;
    endcase
  end

  // Queue control
  assign full       = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;
  assign pop        = q_ctrl_i.pop && (count_q != '0);

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_d;
    end
  end

  assign q_stat_o.valid = (count_q != '0);
  assign q_item_o       = mem_q[rd_ptr_q];

endmodule

// ===== design/mvx_back.sv =====
// Back end: matrix store, 16 multipliers, adder tree, clamp and output register.
module mvx_back import mvx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  qstat_t    q_stat_i,
  input  work_t     q_item_i,
  output qctrl_t    q_ctrl_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  word_t                         mat_q [MAT_DIM][MAT_DIM];
  logic                          adv;
  logic                          pop;
  logic                          s1_v_q;
  logic                          s2_v_q;
  logic                          out_v_q;
  logic signed [PROD_BITS-1:0]   prod_d [MAT_DIM][MAT_DIM];
  logic signed [PROD_BITS-1:0]   s1_prod_q [MAT_DIM][MAT_DIM];
  logic signed [PAIR_BITS-1:0]   pair_d [MAT_DIM][2];
  logic signed [PAIR_BITS-1:0]   s2_pair_q [MAT_DIM][2];
  word_t                         res_d [MAT_DIM];
  logic [MAT_DIM-1:0]            clip_d;
  out_item_t                     out_d;
  out_item_t                     out_q;

  // Whole pipeline moves unless a finished result is held by the sink
  assign adv          = !(out_v_q && out_stall_i);
  assign pop          = adv && q_stat_i.valid;
  assign q_ctrl_o.pop = pop;

  // Matrix store: a load writes one entry as it leaves the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAT_DIM; r++) begin
        for (int c = 0; c < MAT_DIM; c++) begin
          mat_q[r][c] <= '0;
        end
      end
    end else if (pop && (q_item_i.op == OP_LOAD)) begin
      mat_q[q_item_i.row][q_item_i.col] <= q_item_i.vec[0];
    end
  end

  // Stage 1: sixteen full-width products
  always_comb begin
    for (int r = 0; r < MAT_DIM; r++) begin
      for (int c = 0; c < MAT_DIM; c++) begin
        prod_d[r][c] = PROD_BITS'(mat_q[r][c]) * PROD_BITS'($signed(q_item_i.vec[c]));
      end
    end
  end

  // Stage 2: pairwise sums
  always_comb begin
    for (int r = 0; r < MAT_DIM; r++) begin
      pair_d[r][0] = PAIR_BITS'(s1_prod_q[r][0]) + PAIR_BITS'(s1_prod_q[r][1]);
      pair_d[r][1] = PAIR_BITS'(s1_prod_q[r][2]) + PAIR_BITS'(s1_prod_q[r][3]);
    end
  end

  // Stage 3: final sum, floor shift, clamp to the word range
  always_comb begin
    logic signed [SUM_BITS-1:0]   sum;
    logic [SHIFT_BITS-1:0]        sh;
    logic [SHIFT_BITS-WORD_BITS:0] top;
    for (int r = 0; r < MAT_DIM; r++) begin
      sum = SUM_BITS'(s2_pair_q[r][0]) + SUM_BITS'(s2_pair_q[r][1]);
      sh  = sum[SUM_BITS-1:FRAC_BITS];
      top = sh[SHIFT_BITS-1:WORD_BITS-1];
      if ((&top) || !(|top)) begin
        res_d[r]  = sh[WORD_BITS-1:0];
        clip_d[r] = 1'b0;
      end else if (sh[SHIFT_BITS-1]) begin
        res_d[r]  = {1'b1, {(WORD_BITS-1){1'b0}}};
        clip_d[r] = 1'b1;
      end else begin
        res_d[r]  = {1'b0, {(WORD_BITS-1){1'b1}}};
        clip_d[r] = 1'b1;
      end
    end
    out_d.out_x     = IO_BITS'(res_d[0]);
    out_d.out_y     = IO_BITS'(res_d[1]);
    out_d.out_z     = IO_BITS'(res_d[2]);
    out_d.out_w     = IO_BITS'(res_d[3]);
    out_d.saturated = |clip_d;
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= pop && (q_item_i.op == OP_XFORM);
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_prod_q <= prod_d;
      s2_pair_q <= pair_d;
      out_q     <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

// ===== design/mat4_vec4_transform_top.sv =====
// Top level of the 4x4 matrix times 4-vector transform engine.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   in_item_i  (in_item_t)
//   out      source     out_valid_o / out_stall_i out_item_o (out_item_t)
//
// One item per clock sustained while the output is not stalled. A transform
// result passes the queue, then multiply, pair add, final add and clamp stages.
// A load updates the matrix when it leaves the queue and gives no result.
// Reset clears the matrix to zero and empties the queue and pipeline.
// A stall on the output freezes the whole back pipeline; the two-entry queue
// then fills and raises in_stall_o.
module mat4_vec4_transform_top import mvx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  qstat_t q_stat;
  qctrl_t q_ctrl;
  work_t  q_item;

  mvx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_stat_o   (q_stat),
    .q_item_o   (q_item),
    .q_ctrl_i   (q_ctrl)
  );

  mvx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_item_i    (q_item),
    .q_ctrl_o    (q_ctrl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // Back end only pops a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ctrl.pop |-> q_stat.valid)
    else $error("queue popped while empty");

  // An accepted item that is not drained leaves the queue non-empty
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !q_ctrl.pop) |=> q_stat.valid)
    else $error("accepted item lost from queue");

  // A held result freezes the back end
  a_hold_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !q_ctrl.pop)
    else $error("queue popped while output held");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the 4x4 matrix times 4-vector transform engine.
module tb_top import mvx_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACC_BITS    = 2 * WORD_BITS + 2;
  localparam int RAND_ITEMS  = 1250;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int SHOW_LIMIT  = 10;

  localparam logic [IO_BITS-1:0] W_MAX = 32'h7fff_ffff;
  localparam logic [IO_BITS-1:0] W_MIN = 32'h8000_0000;
  localparam logic [IO_BITS-1:0] W_ONE = 32'h0001_0000;
  localparam logic [IO_BITS-1:0] W_HALF = 32'h0000_8000;

  // Matrix copy, vertex prediction and result checking
  class xform_scoreboard;
    word_t     matrix[16];
    out_item_t expected_vertices[$];
    int        failures;

    function new();
      foreach (matrix[i]) matrix[i] = '0;
      failures = 0;
    endfunction

    // Row r of the matrix dot the vector, floor-shifted and clamped
    function out_item_t transform_vertex(in_item_t it);
      word_t                       v[4];
      word_t                       lane[4];
      logic signed [2*WORD_BITS-1:0] prod;
      logic signed [ACC_BITS-1:0]  acc;
      logic signed [ACC_BITS-1:0]  hi_lim;
      logic signed [ACC_BITS-1:0]  lo_lim;
      out_item_t                   res;
      v[0] = it.vec_x[WORD_BITS-1:0];
      v[1] = it.vec_y[WORD_BITS-1:0];
      v[2] = it.vec_z[WORD_BITS-1:0];
      v[3] = it.vec_w[WORD_BITS-1:0];
      hi_lim = ACC_BITS'(2 ** (WORD_BITS - 1) - 1);
      lo_lim = -hi_lim - 1;
      res.saturated = 1'b0;
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int c = 0; c < 4; c++) begin
          prod = matrix[r*4+c] * v[c];
          acc  = acc + prod;
        end
        acc = acc >>> FRAC_BITS;
        if (acc > hi_lim) begin
          lane[r] = hi_lim[WORD_BITS-1:0];
          res.saturated = 1'b1;
        end else if (acc < lo_lim) begin
          lane[r] = lo_lim[WORD_BITS-1:0];
          res.saturated = 1'b1;
        end else begin
          lane[r] = acc[WORD_BITS-1:0];
        end
      end
      res.out_x = lane[0];
      res.out_y = lane[1];
      res.out_z = lane[2];
      res.out_w = lane[3];
      return res;
    endfunction

    // Accepted input item: load updates the matrix, transform queues a result
    function void note_input(in_item_t it);
      if (it.kind == OP_LOAD) begin
        matrix[{it.row, it.col}] = it.entry_value[WORD_BITS-1:0];
      end else begin
        expected_vertices.push_back(transform_vertex(it));
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_vertices.size() == 0) begin
        failures++;
        if (failures <= SHOW_LIMIT)
          $display("unexpected result: x=%h y=%h z=%h w=%h sat=%b",
                   got.out_x, got.out_y, got.out_z, got.out_w, got.saturated);
        return;
      end
      want = expected_vertices.pop_front();
      if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
          got.out_z !== want.out_z || got.out_w !== want.out_w ||
          got.saturated !== want.saturated) begin
        failures++;
        if (failures <= SHOW_LIMIT) begin
          $display("mismatch expected: x=%h y=%h z=%h w=%h sat=%b",
                   want.out_x, want.out_y, want.out_z, want.out_w, want.saturated);
          $display("         actual:   x=%h y=%h z=%h w=%h sat=%b",
                   got.out_x, got.out_y, got.out_z, got.out_w, got.saturated);
        end
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  xform_scoreboard sb;
  bit              gaps_on;
  int              cycle_count;

  mat4_vec4_transform_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Output side: random stalls, none during the quiet stretch
  always @(negedge clk_i) begin
    out_stall_i = gaps_on && ($urandom_range(99) < 8);
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Mostly extremes and small values, the rest full-range
  function automatic logic [IO_BITS-1:0] pick_word();
    case ($urandom_range(9))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3: return '1;
      4, 5: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      default: return $urandom();
    endcase
  endfunction

  // Fully random item; ignored fields carry noise too
  function automatic in_item_t random_item();
    in_item_t it;
    it.kind        = ($urandom_range(99) < 30) ? OP_LOAD : OP_XFORM;
    it.row         = 2'($urandom_range(3));
    it.col         = 2'($urandom_range(3));
    it.entry_value = pick_word();
    it.vec_x       = pick_word();
    it.vec_y       = pick_word();
    it.vec_z       = pick_word();
    it.vec_w       = pick_word();
    return it;
  endfunction

  // Present one item and hold it until accepted
  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 8) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic load_entry(input logic [1:0] r, input logic [1:0] c,
                            input logic [IO_BITS-1:0] val);
    in_item_t it;
    it             = random_item();
    it.kind        = OP_LOAD;
    it.row         = r;
    it.col         = c;
    it.entry_value = val;
    send_item(it);
  endtask

  task automatic xform_vec(input logic [IO_BITS-1:0] x, input logic [IO_BITS-1:0] y,
                           input logic [IO_BITS-1:0] z, input logic [IO_BITS-1:0] w);
    in_item_t it;
    it       = random_item();
    it.kind  = OP_XFORM;
    it.vec_x = x;
    it.vec_y = y;
    it.vec_z = z;
    it.vec_w = w;
    send_item(it);
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_vertices.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb          = new();
    cycle_count = 0;
    gaps_on     = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni  = 1'b1;
    gaps_on = 1'b1;

    // Matrix is all zero straight out of reset
    xform_vec(W_MAX, W_MIN, '1, 32'h0000_0001);
    // Identity through every row and column
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        load_entry(2'(r), 2'(c), (r == c) ? W_ONE : '0);
    xform_vec(W_MAX, W_MIN, '1, W_HALF);
    // Row 0 at full scale: clamp high, then clamp low
    for (int c = 0; c < 4; c++) load_entry(2'd0, 2'(c), W_MAX);
    xform_vec(W_MAX, W_MAX, W_MAX, W_MAX);
    xform_vec(W_MIN, W_MIN, W_MIN, W_MIN);
    // Most negative squared overflows the word
    load_entry(2'd1, 2'd1, W_MIN);
    xform_vec('0, W_MIN, '0, '0);
    // Half times minus one ulp floors to minus one
    load_entry(2'd2, 2'd2, W_HALF);
    xform_vec('0, '0, '1, '0);
    drain_results();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      gaps_on = !(n >= 300 && n < 550);
      if (n == 700) drain_results();
      send_item(random_item());
    end
    gaps_on = 1'b1;
    drain_results();
    repeat (10) @(posedge clk_i);

    if (sb.failures == 0 && sb.expected_vertices.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
